// File: hdl/rc5d_pkg.sv
// Shared types and constants for the RC5 infrared frame decoder.
// Holds the decoder state word layout and the next-state table.
// No dependencies.
`timescale 1ns / 1ps

package rc5d_pkg;

  localparam int ADDR_W = 5;
  localparam int CMD_W = 6;
  localparam int DS_W = 6;
  localparam int BC_W = 4;

  localparam int TABLE_SIZE = 102;

  localparam logic [DS_W-1:0] START_STATE = 6'd33;
  localparam logic [DS_W-1:0] ONE_STATE = 6'd42;
  localparam logic [DS_W-1:0] ZERO_STATE = 6'd50;
  localparam logic [BC_W-1:0] FIRST_CMD_BIT = 4'd7;
  localparam logic [BC_W-1:0] FRAME_BITS = 4'd12;

  // One word of decoder state, kept in the state RAM.
  typedef struct packed {
    logic              prev_toggle;
    logic              toggle;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [BC_W-1:0]   bit_count;
    logic [DS_W-1:0]   decode_state;
  } dec_state_t;

  localparam int STATE_W = $bits(dec_state_t);

  localparam logic [DS_W-1:0] NEXT_STATE_TBL [0:TABLE_SIZE-1] = '{
    6'd1,  6'd0,  6'd2,  6'd0,  6'd3,  6'd0,  6'd4,  6'd0,  6'd5,  6'd0,  6'd6,  6'd0,
    6'd7,  6'd0,  6'd8,  6'd0,  6'd9,  6'd0,  6'd10, 6'd0,  6'd11, 6'd0,  6'd12, 6'd0,
    6'd13, 6'd0,  6'd14, 6'd0,  6'd15, 6'd0,  6'd16, 6'd0,  6'd17, 6'd0,  6'd18, 6'd0,
    6'd19, 6'd0,  6'd20, 6'd0,  6'd20, 6'd21, 6'd0,  6'd22, 6'd0,  6'd23, 6'd26, 6'd24,
    6'd26, 6'd25, 6'd26, 6'd0,  6'd27, 6'd0,  6'd28, 6'd0,  6'd29, 6'd31, 6'd30, 6'd31,
    6'd0,  6'd31, 6'd0,  6'd32, 6'd0,  6'd33, 6'd35, 6'd34, 6'd35, 6'd43, 6'd36, 6'd43,
    6'd37, 6'd0,  6'd38, 6'd40, 6'd39, 6'd40, 6'd0,  6'd40, 6'd0,  6'd41, 6'd0,  6'd42,
    6'd35, 6'd34, 6'd35, 6'd44, 6'd0,  6'd45, 6'd48, 6'd46, 6'd48, 6'd47, 6'd48, 6'd0,
    6'd49, 6'd0,  6'd50, 6'd0,  6'd34, 6'd43
  };

  // Indexes past the table end fall back to state 0.
  function automatic logic [DS_W-1:0] next_state(input logic [DS_W:0] idx);
    logic [DS_W-1:0] ns;
    ns = '0;
    if (int'(idx) < TABLE_SIZE) begin
      ns = NEXT_STATE_TBL[idx];
    end
    return ns;
  endfunction

endpackage

// File: hdl/rc5d_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Read returns the old contents on a same-cycle write. No dependencies.
`timescale 1ns / 1ps

module rc5d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/rc5_ir_frame_decoder_core.sv
// RC5 infrared frame decoder top level.
// Depends on rc5d_pkg and rc5d_ram.
`timescale 1ns / 1ps

// One receiver pin sample is taken per input transfer and every sample yields
// exactly one result transfer; frame_done marks the sample that completed a
// twelve-bit frame (toggle, five address bits, six command bits). The decoder
// state lives in a one-entry state RAM: it is read when a sample is taken and
// written back when that sample moves into the output register, with the write
// data forwarded when the next sample follows directly. Throughput is one sample
// per clock while the output is not stalled by out_ready. The registered RAM
// read issued with the transfer is decoded in the next cycle and lands in the
// output register. After reset the state reads as zero without a clearing pass.
// cfg_wr_en loads own_address at once; write it only while the block is idle.
module rc5_ir_frame_decoder_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [rc5d_pkg::ADDR_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_ir_level,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_frame_done,
  output logic                      out_toggle_bit,
  output logic [rc5d_pkg::ADDR_W-1:0] out_frame_address,
  output logic [rc5d_pkg::CMD_W-1:0]  out_frame_command,
  output logic                      out_address_match,
  output logic                      out_new_key
);

  import rc5d_pkg::*;

  logic [ADDR_W-1:0] own_addr_r;

  logic              s1_valid_r;
  logic              s1_sample_r;
  logic              s1_go;
  logic              in_accept;

  logic              entry_valid_r;
  logic              rd_valid_r;
  logic              fwd_sel_r;
  dec_state_t        fwd_data_r;
  logic [STATE_W-1:0] ram_rd_data;

  dec_state_t        st;
  dec_state_t        st_nxt;
  logic [DS_W-1:0]   ns;
  logic [BC_W-1:0]   bc_inc;
  logic              data_bit;
  logic              emit;
  logic              match;

  logic              out_valid_r;
  logic              out_done_r;
  logic              out_toggle_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [CMD_W-1:0]  out_cmd_r;
  logic              out_match_r;
  logic              out_new_key_r;

  assign s1_go     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_go;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= '0;
    end else if (cfg_wr_en) begin
      own_addr_r <= cfg_wr_data;
    end
  end

  rc5d_ram #(
    .WIDTH(STATE_W),
    .DEPTH(1)
  ) u_state_ram (
    .clk    (clk),
    .wr_en  (s1_go),
    .wr_addr(1'b0),
    .wr_data(st_nxt),
    .rd_en  (in_accept),
    .rd_addr(1'b0),
    .rd_data(ram_rd_data)
  );

  // Capture validity and forwarding for the read issued with this transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      entry_valid_r <= 1'b0;
      rd_valid_r    <= 1'b0;
      fwd_sel_r     <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
        rd_valid_r <= entry_valid_r;
        fwd_sel_r  <= s1_go;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        entry_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample_r <= ~in_ir_level;
      fwd_data_r  <= st_nxt;
    end
  end

  always_comb begin
    if (fwd_sel_r) begin
      st = fwd_data_r;
    end else if (rd_valid_r) begin
      st = dec_state_t'(ram_rd_data);
    end else begin
      st = '0;
    end
  end

  // Advance the table and shift in decoded bits.
  always_comb begin
    ns       = next_state({st.decode_state, s1_sample_r});
    bc_inc   = st.bit_count + 4'd1;
    data_bit = (ns == ONE_STATE);
    emit     = 1'b0;
    match    = 1'b0;
    st_nxt   = st;
    st_nxt.decode_state = ns;
    if (ns == START_STATE) begin
      st_nxt.bit_count = '0;
      st_nxt.addr      = '0;
      st_nxt.cmd       = '0;
    end else if (ns == ONE_STATE || ns == ZERO_STATE) begin
      st_nxt.bit_count = bc_inc;
      if (bc_inc == 4'd1) begin
        st_nxt.toggle = data_bit;
      end else if (bc_inc < FIRST_CMD_BIT) begin
        st_nxt.addr = {st.addr[ADDR_W-2:0], data_bit};
      end else begin
        st_nxt.cmd = {st.cmd[CMD_W-2:0], data_bit};
      end
      if (bc_inc == FRAME_BITS) begin
        emit  = 1'b1;
        match = (st_nxt.addr == own_addr_r);
        st_nxt.bit_count = '0;
        if (match) begin
          st_nxt.prev_toggle = st_nxt.toggle;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_done_r    <= emit;
      out_toggle_r  <= emit & st_nxt.toggle;
      out_addr_r    <= emit ? st_nxt.addr : '0;
      out_cmd_r     <= emit ? st_nxt.cmd : '0;
      out_match_r   <= match;
      out_new_key_r <= match & (st_nxt.toggle ^ st.prev_toggle);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_done    = out_done_r;
  assign out_toggle_bit    = out_toggle_r;
  assign out_frame_address = out_addr_r;
  assign out_frame_command = out_cmd_r;
  assign out_address_match = out_match_r;
  assign out_new_key       = out_new_key_r;

endmodule

// File: hdl/rc5d_checker.sv
// Port-level checks for the RC5 frame decoder, bound to the top level.
// Depends on rc5d_pkg and rc5_ir_frame_decoder_core.
`timescale 1ns / 1ps

module rc5d_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_frame_done,
  input logic                        out_toggle_bit,
  input logic [rc5d_pkg::ADDR_W-1:0] out_frame_address,
  input logic [rc5d_pkg::CMD_W-1:0]  out_frame_command,
  input logic                        out_address_match,
  input logic                        out_new_key
);

  import rc5d_pkg::*;

  a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_done |->
      !out_toggle_bit && out_frame_address == '0 && out_frame_command == '0 &&
      !out_address_match && !out_new_key)
    else $error("result without frame carries nonzero fields");

  a_new_key_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_key |-> out_address_match)
    else $error("new key flagged on a non-matching frame");

  a_match_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_address_match |-> out_frame_done)
    else $error("address match flagged without a finished frame");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_done) &&
      $stable(out_frame_address) && $stable(out_frame_command) &&
      $stable(out_new_key))
    else $error("stalled result changed");

endmodule

bind rc5_ir_frame_decoder_core rc5d_checker u_rc5d_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_frame_done   (out_frame_done),
  .out_toggle_bit   (out_toggle_bit),
  .out_frame_address(out_frame_address),
  .out_frame_command(out_frame_command),
  .out_address_match(out_address_match),
  .out_new_key      (out_new_key)
);
